// ===== hdl/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB color converter.
// Holds the word types of both channels and the hue sector codes.
// No dependencies.
package hsv2rgb_pkg;

   localparam int CHAN_W = 8;

   // Hue sectors, one sixth of a turn each.
   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic [CHAN_W-1:0] hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } hsv_rsp_type;

endpackage

// ===== hdl/hsv_to_rgb_color.sv =====
// HSV to RGB color converter, top level.
// An accepted request word passes stages 1, 2 and 3 and the output stage before it is a valid response word.
// Throughput: one word per cycle while rsp_stall is low; each stage refills as soon as it empties.
// The depth is set by the hue split stage, the two dependent multiplier levels and the output stage.
// Reset clears all stage valid bits; payload registers are not reset.
// Depends on hsv2rgb_pkg.
module hsv_to_rgb_color (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hsv2rgb_pkg::hsv_req_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hsv2rgb_pkg::hsv_rsp_type rsp_word
);
   import hsv2rgb_pkg::*;

   // Stage 1: sector and fraction of the hue.
   logic              s1_valid_ff;
   logic [2:0]        s1_sector_ff, s1_sector_in;
   logic [7:0]        s1_frac_ff, s1_frac_in;
   logic [7:0]        s1_sat_ff;
   logic [7:0]        s1_bri_ff;
   // Stage 2: scaled saturations and the p level.
   logic              s2_valid_ff;
   logic [2:0]        s2_sector_ff;
   logic [7:0]        s2_bri_ff;
   logic [7:0]        s2_sf_ff, s2_sf_in;
   logic [7:0]        s2_sg_ff, s2_sg_in;
   logic [7:0]        s2_p_ff, s2_p_in;
   // Stage 3: q and t levels.
   logic              s3_valid_ff;
   logic [2:0]        s3_sector_ff;
   logic [7:0]        s3_bri_ff;
   logic [7:0]        s3_p_ff;
   logic [7:0]        s3_q_ff, s3_q_in;
   logic [7:0]        s3_t_ff, s3_t_in;
   // Output stage.
   logic              out_valid_ff;
   hsv_rsp_type       out_word_ff, out_word_in;

   logic              en1, en2, en3, en_out;
   logic [10:0]       hue_x6;
   logic [17:0]       sf_prod, sg_prod, p_prod, q_prod, t_prod;
   logic [7:0]        lvl_r, lvl_g, lvl_b;

   // A stage loads when it is empty or its contents move on.
   assign en_out    = !out_valid_ff || !rsp_stall;
   assign en3       = !s3_valid_ff || en_out;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   // Hue times six by shift and add; the top bits are the sector.
   always_comb begin
      hue_x6       = {1'b0, req_word.hue, 2'b00} + {2'b00, req_word.hue, 1'b0};
      s1_sector_in = hue_x6[10:8];
      s1_frac_in   = hue_x6[7:0];
   end

   // One multiply level: s*f, s*(1-f) and v*(1-s), all truncated to Q0.8.
   always_comb begin
      sf_prod = {10'd0, s1_sat_ff} * {10'd0, s1_frac_ff};
      sg_prod = {10'd0, s1_sat_ff} * (18'd256 - {10'd0, s1_frac_ff});
      p_prod  = {10'd0, s1_bri_ff} * (18'd256 - {10'd0, s1_sat_ff});
      s2_sf_in = sf_prod[15:8];
      s2_sg_in = sg_prod[15:8];
      s2_p_in  = p_prod[15:8];
   end

   // Second multiply level: v*(1-s*f) and v*(1-s*(1-f)).
   // Zero saturation makes p, q and t all equal to v, so gray needs no special path.
   always_comb begin
      q_prod  = {10'd0, s2_bri_ff} * (18'd256 - {10'd0, s2_sf_ff});
      t_prod  = {10'd0, s2_bri_ff} * (18'd256 - {10'd0, s2_sg_ff});
      s3_q_in = q_prod[15:8];
      s3_t_in = t_prod[15:8];
   end

   // Sector permutation of the levels.
   always_comb begin
      unique case (s3_sector_ff)
         SECTOR_RED_YELLOW: begin
            lvl_r = s3_bri_ff; lvl_g = s3_t_ff;   lvl_b = s3_p_ff;
         end
         SECTOR_YELLOW_GREEN: begin
            lvl_r = s3_q_ff;   lvl_g = s3_bri_ff; lvl_b = s3_p_ff;
         end
         SECTOR_GREEN_CYAN: begin
            lvl_r = s3_p_ff;   lvl_g = s3_bri_ff; lvl_b = s3_t_ff;
         end
         SECTOR_CYAN_BLUE: begin
            lvl_r = s3_p_ff;   lvl_g = s3_q_ff;   lvl_b = s3_bri_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            lvl_r = s3_t_ff;   lvl_g = s3_p_ff;   lvl_b = s3_bri_ff;
         end
         default: begin
            lvl_r = s3_bri_ff; lvl_g = s3_p_ff;   lvl_b = s3_q_ff;
         end
      endcase
   end

   // Scaling by 255/256 with truncation is the level minus one, except at zero.
   always_comb begin
      out_word_in.red   = lvl_r - {7'd0, (lvl_r != 8'd0)};
      out_word_in.green = lvl_g - {7'd0, (lvl_g != 8'd0)};
      out_word_in.blue  = lvl_b - {7'd0, (lvl_b != 8'd0)};
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1)    s1_valid_ff  <= req_valid;
         if (en2)    s2_valid_ff  <= s1_valid_ff;
         if (en3)    s3_valid_ff  <= s2_valid_ff;
         if (en_out) out_valid_ff <= s3_valid_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= req_word.saturation;
         s1_bri_ff    <= req_word.brightness;
      end
      if (en2) begin
         s2_sector_ff <= s1_sector_ff;
         s2_bri_ff    <= s1_bri_ff;
         s2_sf_ff     <= s2_sf_in;
         s2_sg_ff     <= s2_sg_in;
         s2_p_ff      <= s2_p_in;
      end
      if (en3) begin
         s3_sector_ff <= s2_sector_ff;
         s3_bri_ff    <= s2_bri_ff;
         s3_p_ff      <= s2_p_ff;
         s3_q_ff      <= s3_q_in;
         s3_t_ff      <= s3_t_in;
      end
      if (en_out) begin
         out_word_ff  <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // The input side only stalls when the first stage holds a word.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty first stage");

   // A word waiting in stage 3 replaces a delivered response at once.
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && s3_valid_ff) |=> rsp_valid)
      else $error("output stage failed to refill from stage 3");

   // Scaled channels never reach full scale.
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.red != 8'hFF && rsp_word.green != 8'hFF &&
                     rsp_word.blue != 8'hFF))
      else $error("channel value above scaled maximum");

endmodule
